/* rtl/core/kwfd_pkg.sv */
// Shared types and constants of the keyed window failure detector.
`default_nettype none

package kwfd_pkg;

  localparam int unsigned IDX_W      = 8;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned THR_W      = 4;
  localparam int unsigned SPAN_W     = 32;
  localparam int unsigned TOTAL_W    = 16;
  localparam int unsigned HITS_W     = 4;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned RES_W      = 1 + TOTAL_W + HITS_W + 1;

  localparam logic [THR_W-1:0]  THR_RESET  = 4'd3;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 32'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALERT_THRESHOLD = 4'd0,
    REG_WINDOW_SPAN     = 4'd1
  } cfg_reg_e;

  typedef enum logic {
    REQ_FAIL  = 1'b0,
    REQ_RESET = 1'b1
  } req_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_WALK,
    ST_CMP,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

/* rtl/core/kwfd_fifo.sv */
// Small first-in first-out queue of words with show-ahead output.
`default_nettype none

module kwfd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kwfd_front.sv */
// Front end: accepts events, reduces the key and the time, queues a command word.
`default_nettype none

module kwfd_front import kwfd_pkg::*; #(
  parameter int unsigned KEY_SLOTS = 256,
  parameter int unsigned TIME_BITS = 32,
  localparam int unsigned KEY_W    = $clog2(KEY_SLOTS),
  localparam int unsigned CMD_W    = 1 + KEY_W + TIME_BITS
) (
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic             req_type_i,
  input  wire logic [IDX_W-1:0] user_index_i,
  input  wire logic [NOW_W-1:0] now_time_i,
  input  wire logic             q_full_i,
  input  wire logic             clearing_i,
  output logic                  cmd_push_o,
  output logic      [CMD_W-1:0] cmd_data_o
);

  logic [KEY_W:0]        rem;
  logic [KEY_W-1:0]      key;
  logic [TIME_BITS-1:0]  now_t;
  logic                  is_reset;

  // Reduce the index modulo the slot count, one bit per step, MSB first.
  always_comb begin
    rem = '0;
    for (int b = IDX_W - 1; b >= 0; b--) begin
      rem = {rem[KEY_W-1:0], user_index_i[b]};
      if (rem >= (KEY_W + 1)'(KEY_SLOTS)) begin
        rem = rem - (KEY_W + 1)'(KEY_SLOTS);
      end
    end
    key = rem[KEY_W-1:0];
  end

  assign now_t      = TIME_BITS'(now_time_i);
  assign is_reset   = (req_type_i == REQ_RESET);
  assign full_o     = q_full_i || clearing_i;
  assign cmd_push_o = push_i && !full_o;
  assign cmd_data_o = {is_reset, key, now_t};

endmodule

`default_nettype wire

/* rtl/core/kwfd_back.sv */
// Back end: key table, stamp memory, window walk and result build.
`default_nettype none

module kwfd_back import kwfd_pkg::*; #(
  parameter int unsigned KEY_SLOTS  = 256,
  parameter int unsigned HISTORY    = 8,
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned COUNT_BITS = 16,
  localparam int unsigned KEY_W     = $clog2(KEY_SLOTS),
  localparam int unsigned CMD_W     = 1 + KEY_W + TIME_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_wr_t          cfg_i,
  input  wire logic [CMD_W-1:0] cmd_data_i,
  input  wire logic             cmd_empty_i,
  output logic                  cmd_pop_o,
  output logic      [RES_W-1:0] res_data_o,
  input  wire logic             res_full_i,
  output logic                  res_push_o,
  output logic                  clearing_o
);

  localparam int unsigned HEAD_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int unsigned FILL_W = $clog2(HISTORY + 1);
  localparam int unsigned META_W = 1 + COUNT_BITS + HEAD_W + FILL_W;
  localparam int unsigned SA_W   = $clog2(KEY_SLOTS * HISTORY);
  localparam int unsigned AGE_W  = (TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W;
  localparam int unsigned TOT_XW = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
  localparam int unsigned RUN_XW = (FILL_W > HITS_W) ? FILL_W : HITS_W;
  localparam int unsigned CNT_XW = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  function automatic logic [HEAD_W-1:0] prev_pos(input logic [HEAD_W-1:0] p);
    prev_pos = (p == '0) ? HEAD_W'(HISTORY - 1) : p - 1'b1;
  endfunction

  logic [META_W-1:0]    meta_mem [KEY_SLOTS];
  logic [TIME_BITS-1:0] stamp_mem [KEY_SLOTS * HISTORY];

  back_state_e           state_q, state_d;
  logic [KEY_W-1:0]      clr_idx_q, clr_idx_d;
  logic [THR_W-1:0]      thr_q, thr_d;
  logic [SPAN_W-1:0]     span_q, span_d;
  logic                  is_rst_q, is_rst_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [TIME_BITS-1:0]  now_q, now_d;
  logic [SA_W-1:0]       base_q, base_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [FILL_W-1:0]     run_q, run_d;
  logic [FILL_W-1:0]     left_q, left_d;
  logic [HEAD_W-1:0]     pos_q, pos_d;
  logic                  existed_q, existed_d;
  logic [META_W-1:0]     meta_rdata_q;
  logic [TIME_BITS-1:0]  stamp_rdata_q;

  logic                  cmd_rst;
  logic [KEY_W-1:0]      cmd_key;
  logic [TIME_BITS-1:0]  cmd_now;

  logic                  m_valid;
  logic [COUNT_BITS-1:0] m_cnt;
  logic [HEAD_W-1:0]     m_head;
  logic [FILL_W-1:0]     m_fill;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [HEAD_W-1:0]     wpos, new_head;
  logic [FILL_W-1:0]     new_fill;
  logic [TIME_BITS-1:0]  age;
  logic                  hit;

  logic                  meta_re, meta_we, stamp_re, stamp_we;
  logic [KEY_W-1:0]      meta_waddr;
  logic [META_W-1:0]     meta_wdata;
  logic [SA_W-1:0]       stamp_raddr, stamp_waddr;

  logic                  alert;
  logic [TOTAL_W-1:0]    total;
  logic [HITS_W-1:0]     hits;
  logic [TOT_XW-1:0]     cnt_x;
  logic [RUN_XW-1:0]     run_x;

  assign {cmd_rst, cmd_key, cmd_now} = cmd_data_i;
  assign {m_valid, m_cnt, m_head, m_fill} = meta_rdata_q;

  // Entry update for a failure event.
  always_comb begin
    wpos     = m_valid ? m_head : '0;
    new_head = (wpos == HEAD_W'(HISTORY - 1)) ? '0 : wpos + 1'b1;
    if (!m_valid) begin
      new_cnt  = COUNT_BITS'(1);
      new_fill = FILL_W'(1);
    end else begin
      new_cnt  = (m_cnt == '1) ? m_cnt : m_cnt + 1'b1;
      new_fill = (m_fill == FILL_W'(HISTORY)) ? m_fill : m_fill + 1'b1;
    end
    age = now_q - stamp_rdata_q;
    hit = (AGE_W'(age) <= AGE_W'(span_q));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == KEY_W'(KEY_SLOTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!cmd_empty_i) state_d = ST_META;
      end
      ST_META: begin
        if (is_rst_q || new_fill == FILL_W'(1)) state_d = ST_DONE;
        else state_d = ST_WALK;
      end
      ST_WALK: state_d = ST_CMP;
      ST_CMP: begin
        if (hit && left_q != FILL_W'(1)) state_d = ST_WALK;
        else state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs and memory ports.
  always_comb begin
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    clearing_o  = 1'b0;
    meta_re     = 1'b0;
    meta_we     = 1'b0;
    meta_waddr  = key_q;
    meta_wdata  = {1'b1, new_cnt, new_head, new_fill};
    stamp_re    = 1'b0;
    stamp_we    = 1'b0;
    stamp_raddr = base_q + SA_W'(prev_pos(pos_q));
    stamp_waddr = base_q + SA_W'(wpos);
    case (state_q)
      ST_CLEAR: begin
        clearing_o = 1'b1;
        meta_we    = 1'b1;
        meta_waddr = clr_idx_q;
        meta_wdata = '0;
      end
      ST_IDLE: begin
        cmd_pop_o = !cmd_empty_i;
        meta_re   = !cmd_empty_i;
      end
      ST_META: begin
        meta_we  = 1'b1;
        stamp_we = !is_rst_q;
        if (is_rst_q) meta_wdata = {1'b0, meta_rdata_q[META_W-2:0]};
      end
      ST_WALK: stamp_re = 1'b1;
      ST_CMP: ;
      ST_DONE: res_push_o = !res_full_i;
      default: ;
    endcase
  end

  // Datapath and configuration next values.
  always_comb begin
    clr_idx_d = clr_idx_q;
    thr_d     = thr_q;
    span_d    = span_q;
    is_rst_d  = is_rst_q;
    key_d     = key_q;
    now_d     = now_q;
    base_d    = base_q;
    cnt_d     = cnt_q;
    run_d     = run_q;
    left_d    = left_q;
    pos_d     = pos_q;
    existed_d = existed_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == REG_ALERT_THRESHOLD) thr_d = cfg_i.data[THR_W-1:0];
      if (cfg_i.index == REG_WINDOW_SPAN) span_d = cfg_i.data[SPAN_W-1:0];
    end
    case (state_q)
      ST_CLEAR: clr_idx_d = clr_idx_q + 1'b1;
      ST_IDLE: begin
        is_rst_d = cmd_rst;
        key_d    = cmd_key;
        now_d    = cmd_now;
        base_d   = SA_W'(cmd_key) * SA_W'(HISTORY);
      end
      ST_META: begin
        existed_d = m_valid;
        if (is_rst_q) begin
          cnt_d = '0;
          run_d = '0;
        end else begin
          // The new stamp is the newest and always inside the window.
          cnt_d  = new_cnt;
          run_d  = FILL_W'(1);
          left_d = new_fill - 1'b1;
          pos_d  = wpos;
        end
      end
      ST_WALK: pos_d = prev_pos(pos_q);
      ST_CMP: begin
        if (hit) begin
          run_d  = run_q + 1'b1;
          left_d = left_q - 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Result word.
  always_comb begin
    cnt_x = TOT_XW'(cnt_q);
    run_x = RUN_XW'(run_q);
    total = (cnt_x > TOT_XW'({TOTAL_W{1'b1}})) ? '1 : cnt_x[TOTAL_W-1:0];
    hits  = (run_x > RUN_XW'({HITS_W{1'b1}})) ? '1 : run_x[HITS_W-1:0];
    alert = !is_rst_q && (CNT_XW'(cnt_q) >= CNT_XW'(thr_q)) &&
            (RUN_XW'(run_q) >= RUN_XW'(thr_q));
    res_data_o = {alert, total, hits, existed_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      thr_q     <= THR_RESET;
      span_q    <= SPAN_RESET;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      thr_q     <= thr_d;
      span_q    <= span_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_rst_q  <= is_rst_d;
    key_q     <= key_d;
    now_q     <= now_d;
    base_q    <= base_d;
    cnt_q     <= cnt_d;
    run_q     <= run_d;
    left_q    <= left_d;
    pos_q     <= pos_d;
    existed_q <= existed_d;
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (meta_re) meta_rdata_q <= meta_mem[cmd_key];
  end

  always_ff @(posedge clk_i) begin
    if (stamp_we) stamp_mem[stamp_waddr] <= now_q;
    if (stamp_re) stamp_rdata_q <= stamp_mem[stamp_raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/keyed_window_failure_detector.sv */
// Top level of the keyed window failure detector.
//
//   channel   direction  handshake          payload
//   event     in         push / full        req_type, user_index, now_time
//   result    out        empty / pop        fraud_alert, failure_total,
//                                           recent_hits, record_existed
//   config    in         cfg_valid / ready  cfg_index, cfg_data
//
// A failure event passes the back-end states META, then WALK and CMP for each
// of k older stamps walked (at most HISTORY-1), then DONE; a reset event goes
// from META straight to DONE. The walk reads a stamp in WALK, compares it in CMP.
// After reset the key table is cleared slot by slot; full stays high
// meanwhile, while configuration writes are taken at all times.
// Two-word queues on each side let the event and result channels stall apart.
`default_nettype none

module keyed_window_failure_detector import kwfd_pkg::*; #(
  parameter int unsigned KEY_SLOTS  = 256,
  parameter int unsigned HISTORY    = 8,
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  req_type_i,
  input  wire logic [IDX_W-1:0]      user_index_i,
  input  wire logic [NOW_W-1:0]      now_time_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic                       fraud_alert_o,
  output logic      [TOTAL_W-1:0]    failure_total_o,
  output logic      [HITS_W-1:0]     recent_hits_o,
  output logic                       record_existed_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned KEY_W = $clog2(KEY_SLOTS);
  localparam int unsigned CMD_W = 1 + KEY_W + TIME_BITS;

  logic             cmd_push, cmd_full, cmd_pop, cmd_empty, clearing;
  logic [CMD_W-1:0] cmd_in, cmd_out;
  logic             res_push, res_full;
  logic [RES_W-1:0] res_in, res_out;
  cfg_wr_t          cfg_wr;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  kwfd_front #(
    .KEY_SLOTS (KEY_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .push_i       (push),
    .full_o       (full),
    .req_type_i   (req_type_i),
    .user_index_i (user_index_i),
    .now_time_i   (now_time_i),
    .q_full_i     (cmd_full),
    .clearing_i   (clearing),
    .cmd_push_o   (cmd_push),
    .cmd_data_o   (cmd_in)
  );

  kwfd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  kwfd_back #(
    .KEY_SLOTS  (KEY_SLOTS),
    .HISTORY    (HISTORY),
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .cmd_data_i  (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_data_o  (res_in),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .clearing_o  (clearing)
  );

  kwfd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign {fraud_alert_o, failure_total_o, recent_hits_o, record_existed_o} = res_out;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench of the keyed window failure detector.
`default_nettype none

module tb_top;
  import kwfd_pkg::*;

  localparam int unsigned SLOTS       = 256;
  localparam int unsigned RING        = 8;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    logic               alert;
    logic [TOTAL_W-1:0] total;
    logic [HITS_W-1:0]  hits;
    logic               existed;
  } login_verdict_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  push         = 1'b0;
  logic                  full;
  logic                  req_type_i   = 1'b0;
  logic [IDX_W-1:0]      user_index_i = '0;
  logic [NOW_W-1:0]      now_time_i   = '0;
  logic                  empty;
  logic                  pop          = 1'b0;
  logic                  fraud_alert_o;
  logic [TOTAL_W-1:0]    failure_total_o;
  logic [HITS_W-1:0]     recent_hits_o;
  logic                  record_existed_o;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  // Shadow of the key table and the registers
  bit                 slot_live   [SLOTS];
  logic [TOTAL_W-1:0] slot_fails  [SLOTS];
  logic [NOW_W-1:0]   slot_stamps [SLOTS][RING];
  logic [2:0]         slot_head   [SLOTS];
  int unsigned        slot_fill   [SLOTS];
  logic [THR_W-1:0]   cur_thr  = THR_RESET;
  logic [SPAN_W-1:0]  win_span = SPAN_RESET;

  login_verdict_t pending_verdicts [$];
  int unsigned    mismatch_count = 0;
  int unsigned    quiet_cycles   = 0;
  int unsigned    send_idle_pct  = 0;
  int unsigned    pop_stall_pct  = 0;
  int unsigned    hold_left      = 0;
  logic           stall_go       = 1'b0;
  logic           stall_seen     = 1'b0;

  keyed_window_failure_detector uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .req_type_i       (req_type_i),
    .user_index_i     (user_index_i),
    .now_time_i       (now_time_i),
    .empty            (empty),
    .pop              (pop),
    .fraud_alert_o    (fraud_alert_o),
    .failure_total_o  (failure_total_o),
    .recent_hits_o    (recent_hits_o),
    .record_existed_o (record_existed_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic login_verdict_t judge_event(input req_kind_e kind,
                                                 input logic [IDX_W-1:0] key,
                                                 input logic [NOW_W-1:0] now);
    login_verdict_t v;
    int unsigned    run;
    int unsigned    i;
    logic [2:0]     pos;
    logic [NOW_W-1:0] age;
    logic           stop;
    v = '0;
    v.existed = slot_live[key];
    if (kind == REQ_RESET) begin
      slot_live[key] = 1'b0;
    end else begin
      if (!slot_live[key]) begin
        slot_live[key] = 1'b1;
        slot_fails[key] = TOTAL_W'(1);
        slot_head[key] = '0;
        slot_fill[key] = 0;
      end else if (slot_fails[key] != '1) begin
        slot_fails[key] = slot_fails[key] + 1'b1;
      end
      slot_stamps[key][slot_head[key]] = now;
      slot_head[key] = slot_head[key] + 3'd1;
      if (slot_fill[key] < RING) slot_fill[key]++;
      // walk back from the newest stamp while its age stays inside the window
      run = 0;
      stop = 1'b0;
      pos = slot_head[key];
      for (i = 0; i < slot_fill[key]; i++) begin
        if (!stop) begin
          pos = pos - 3'd1;
          age = now - slot_stamps[key][pos];
          if (age > win_span) stop = 1'b1;
          else run++;
        end
      end
      v.total = slot_fails[key];
      v.hits  = (run > 15) ? 4'd15 : HITS_W'(run);
      v.alert = (slot_fails[key] >= cur_thr) && (run >= int'(cur_thr));
    end
    return v;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic offer_event(input req_kind_e kind, input logic [IDX_W-1:0] key,
                             input logic [NOW_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    req_type_i   <= kind;
    user_index_i <= key;
    now_time_i   <= now;
    do @(posedge clk_i); while (full);
    pending_verdicts.insert(pending_verdicts.size(), judge_event(kind, key, now));
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_ALERT_THRESHOLD) cur_thr = data[THR_W-1:0];
    else if (idx == REG_WINDOW_SPAN) win_span = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  // Pop side: check each accepted word, then pick the next pop value
  always @(posedge clk_i) begin
    login_verdict_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result word with no event waiting", $time);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("fraud_alert", 32'(want.alert), 32'(fraud_alert_o));
        compare_field("failure_total", 32'(want.total), 32'(failure_total_o));
        compare_field("recent_hits", 32'(want.hits), 32'(recent_hits_o));
        compare_field("record_existed", 32'(want.existed), 32'(record_existed_o));
      end
    end
    if (stall_go != stall_seen) begin
      stall_seen <= stall_go;
      hold_left  <= HOLD_CYCLES;
      pop        <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed_events();
    int i;
    offer_event(REQ_RESET, 8'd0, 32'd0);
    offer_event(REQ_FAIL, 8'd0, 32'd10);
    offer_event(REQ_FAIL, 8'd0, 32'd20);
    offer_event(REQ_FAIL, 8'd0, 32'd30);
    offer_event(REQ_RESET, 8'd0, 32'd31);
    // wrap of the time base: the old stamp is still recent
    offer_event(REQ_FAIL, 8'd255, 32'hFFFF_FFF0);
    offer_event(REQ_FAIL, 8'd255, 32'd5);
    offer_event(REQ_FAIL, 8'd255, 32'd8);
    // stamp from the future counts as very old
    offer_event(REQ_FAIL, 8'd7, 32'd1000);
    offer_event(REQ_FAIL, 8'd7, 32'd500);
    offer_event(REQ_FAIL, 8'd9, 32'd0);
    offer_event(REQ_FAIL, 8'd9, 32'd100);
    offer_event(REQ_FAIL, 8'd9, 32'd200);
    // overfill the ring
    for (i = 0; i < 9; i++) offer_event(REQ_FAIL, 8'd3, 32'd40);
  endtask

  task automatic test_register_extremes();
    drain_results();
    write_setting(REG_ALERT_THRESHOLD, 32'd0);
    write_setting(REG_WINDOW_SPAN, 32'd0);
    offer_event(REQ_FAIL, 8'd1, 32'd0);
    offer_event(REQ_RESET, 8'd1, 32'd0);
    drain_results();
    // threshold above ring depth never alerts
    write_setting(REG_ALERT_THRESHOLD, 32'd9);
    write_setting(REG_WINDOW_SPAN, 32'hFFFF_FFFF);
    offer_event(REQ_FAIL, 8'd3, 32'd41);
    drain_results();
    write_setting(REG_ALERT_THRESHOLD, 32'hFFFF_FFF8);
    write_setting(4'hF, 32'hFFFF_FFFF);
    write_setting(CFG_IDX_W'($urandom_range(14, 2)), $urandom());
    offer_event(REQ_FAIL, 8'd3, 32'd42);
    drain_results();
    write_setting(REG_ALERT_THRESHOLD, 32'd15);
    offer_event(REQ_FAIL, 8'd2, 32'd1);
    drain_results();
    write_setting(REG_ALERT_THRESHOLD, 32'(THR_RESET));
    write_setting(REG_WINDOW_SPAN, 32'(SPAN_RESET));
  endtask

  task automatic test_full_backpressure();
    int i;
    drain_results();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    stall_go <= ~stall_go;
    for (i = 0; i < 40; i++) begin
      offer_event(($urandom_range(9) == 0) ? REQ_RESET : REQ_FAIL,
                  IDX_W'($urandom_range(3)), 32'd100000 + i);
    end
  endtask

  task automatic test_random_traffic(input int unsigned send_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned items);
    logic [IDX_W-1:0]  pool [6];
    logic [IDX_W-1:0]  key;
    logic [NOW_W-1:0]  now_t;
    logic [NOW_W-1:0]  step_cap;
    logic [SPAN_W-1:0] span_pick;
    logic [THR_W-1:0]  thr_pick;
    req_kind_e         kind;
    int unsigned       seg;
    int unsigned       n;
    int unsigned       k;
    for (seg = 0; seg < 2; seg++) begin
      drain_results();
      send_idle_pct = send_pct;
      pop_stall_pct = stall_pct;
      thr_pick = ($urandom_range(99) < 85) ? THR_W'($urandom_range(8, 1))
                                           : THR_W'($urandom_range(15));
      case ($urandom_range(4))
        0:       span_pick = '0;
        1:       span_pick = '1;
        2:       span_pick = $urandom();
        default: span_pick = $urandom_range(300, 1);
      endcase
      write_setting(REG_ALERT_THRESHOLD, ($urandom() & ~32'hF) | thr_pick);
      write_setting(REG_WINDOW_SPAN, span_pick);
      for (k = 0; k < 6; k++) pool[k] = IDX_W'($urandom_range(255));
      now_t = $urandom();
      step_cap = (span_pick > 300000) ? 100000 : span_pick / 3 + 2;
      for (n = 0; n < items / 2; n++) begin
        key  = ($urandom_range(99) < 90) ? pool[$urandom_range(5)]
                                         : IDX_W'($urandom_range(255));
        kind = ($urandom_range(99) < 12) ? REQ_RESET : REQ_FAIL;
        now_t = now_t + $urandom_range(step_cap);
        // jump the clock now and then
        offer_event(kind, key, ($urandom_range(99) < 5) ? $urandom() : now_t);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_events();
    test_register_extremes();
    test_full_backpressure();
    test_random_traffic(0, 0, 220);
    test_random_traffic(83, 0, 220);
    test_random_traffic(0, 83, 220);
    test_random_traffic(11, 11, 220);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
